// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers: clock i_clk, synchronous active-low reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ucpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ucpr_pkg
// Types, widths and helpers for the use-count page replacement core.
// ----------------------------------------------------------------------------
package ucpr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 8;
    localparam int COUNT_BITS = 16;

    localparam int IDX_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NUM_BITS = $clog2(MAX_FRAMES + 1);

    // fixed field widths of the channels
    localparam int CFG_W    = 5;
    localparam int PAGE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int ACTION_W = 2;
    localparam int EVICT_W  = 8;
    localparam int USE_W    = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic [ACTION_W-1:0] {
        ACT_HIT     = 2'd0,
        ACT_FILL    = 2'd1,
        ACT_REPLACE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_BITS-1:0]   t_idx;

    typedef struct packed {
        logic   we;
        t_idx   idx;
        t_page  page;
        t_count cnt;
    } t_frame_wr;

    typedef struct packed {
        logic match;
        logic empty;
        logic less;
    } t_cmp_res;

    function automatic t_count sat_inc(t_count c);
        t_count r;
        r = (c == '1) ? c : c + t_count'(1);
        return r;
    endfunction

endpackage

// ===== src/ucpr_ifs.sv =====
// ----------------------------------------------------------------------------
// ucpr_ifs
// Valid/ready channels for page requests and replacement results.
// ----------------------------------------------------------------------------
interface ucpr_in_if;
    import ucpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface ucpr_out_if;
    import ucpr_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [INDEX_W-1:0] frame_index;
    t_action            action;
    logic [EVICT_W-1:0] evicted_page;
    logic [USE_W-1:0]   use_count;

    modport source (output valid, output hit, output frame_index, output action,
                    output evicted_page, output use_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input action,
                    input evicted_page, input use_count, output ready);
endinterface

// ===== src/ucpr_frame_store.sv =====
// ----------------------------------------------------------------------------
// ucpr_frame_store
// Page number and use counter per frame; one read index, one write port.
// ----------------------------------------------------------------------------
module ucpr_frame_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ucpr_pkg::t_idx        i_rd_idx,
    output ucpr_pkg::t_page       o_rd_page,
    output ucpr_pkg::t_count      o_rd_cnt,
    input  ucpr_pkg::t_frame_wr   i_wr
);
    import ucpr_pkg::*;

    t_page  r_page [MAX_FRAMES];
    t_count r_cnt  [MAX_FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_page[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else if (i_wr.we) begin
            r_page[i_wr.idx] <= i_wr.page;
            r_cnt[i_wr.idx]  <= i_wr.cnt;
        end
    end

    assign o_rd_page = r_page[i_rd_idx];
    assign o_rd_cnt  = r_cnt[i_rd_idx];

endmodule

// ===== src/ucpr_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// ucpr_cmp_unit
// Per-frame compare step: page match, empty frame, and new minimum count.
// ----------------------------------------------------------------------------
module ucpr_cmp_unit (
    input  ucpr_pkg::t_page    i_frame_page,
    input  ucpr_pkg::t_count   i_frame_cnt,
    input  ucpr_pkg::t_page    i_req_page,
    input  ucpr_pkg::t_count   i_min_cnt,
    input  logic               i_first,
    output ucpr_pkg::t_cmp_res o_res
);
    import ucpr_pkg::*;

    always_comb begin
        o_res.match = (i_frame_page == i_req_page);
        o_res.empty = (i_frame_page == '0);
        // strict less keeps the lowest index on a tie
        o_res.less  = i_first || (i_frame_cnt < i_min_cnt);
    end

endmodule

// ===== src/use_count_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// use_count_page_replacement_core
// Page replacement by use count over a small set of frames.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one page request per transfer; o_out returns one result per
//   request (hit, frame index, action, evicted page, new use count).
//   i_cfg_we / i_cfg_wdata set the number of frames in use (0 reads as 1,
//   values above the frame count saturate); write it only while idle.
// Timing:
//   A request is taken only while the core is idle. The frame store is read
//   one frame per cycle through a single compare unit: the scan covers the
//   frames in use (stopping early on a hit), then the update state writes the
//   frame and loads the output register. No new request is taken until the
//   update state has written the result and the core is idle again.
// Stall:
//   A result held in the output register does not block the next request;
//   a second result waits in the update state until the first one transfers.
// Reset:
//   Synchronous; all frames empty with zero counts, frames in use = 16.
// ----------------------------------------------------------------------------
module use_count_page_replacement_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ucpr_pkg::CFG_W-1:0]   i_cfg_wdata,
    ucpr_in_if.sink                      i_in,
    ucpr_out_if.source                   o_out
);
    import ucpr_pkg::*;

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_frames;

    t_idx   r_j, n_j;
    t_page  r_page, n_page;
    logic   r_found, n_found;
    logic   r_have_empty, n_have_empty;
    t_idx   r_sel_idx, n_sel_idx;
    t_count r_sel_cnt, n_sel_cnt;
    t_idx   r_emp_idx, n_emp_idx;
    t_count r_emp_cnt, n_emp_cnt;
    t_idx   r_min_idx, n_min_idx;
    t_count r_min_cnt, n_min_cnt;
    t_page  r_min_page, n_min_page;

    logic               r_o_valid, n_o_valid;
    logic               r_o_hit, n_o_hit;
    logic [INDEX_W-1:0] r_o_idx, n_o_idx;
    t_action            r_o_action, n_o_action;
    logic [EVICT_W-1:0] r_o_evict, n_o_evict;
    logic [USE_W-1:0]   r_o_count, n_o_count;

    logic [NUM_BITS-1:0] w_active;
    logic       w_last;
    logic       w_in_ready, w_scan_en, w_upd_go;
    t_page      w_rd_page;
    t_count     w_rd_cnt;
    t_cmp_res   w_cmp;
    t_frame_wr  w_wr;
    t_idx       w_ch_idx;
    t_count     w_ch_cnt;
    t_count     w_new_cnt;

    // clamp frame count to 1..MAX_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_active = NUM_BITS'(1);
        end else if (32'(r_frames) > 32'(MAX_FRAMES)) begin
            w_active = NUM_BITS'(MAX_FRAMES);
        end else begin
            w_active = NUM_BITS'(r_frames);
        end
    end

    assign w_last = ((NUM_BITS'(r_j) + NUM_BITS'(1)) == w_active);

    ucpr_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_j),
        .o_rd_page (w_rd_page),
        .o_rd_cnt  (w_rd_cnt),
        .i_wr      (w_wr)
    );

    ucpr_cmp_unit u_cmp (
        .i_frame_page (w_rd_page),
        .i_frame_cnt  (w_rd_cnt),
        .i_req_page   (r_page),
        .i_min_cnt    (r_min_cnt),
        .i_first      (r_j == '0),
        .o_res        (w_cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_cmp.match || w_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!r_o_valid || o_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_scan_en  = 1'b0;
        w_upd_go   = 1'b0;
        unique case (r_state)
            ST_IDLE:   w_in_ready = 1'b1;
            ST_SCAN:   w_scan_en  = 1'b1;
            ST_UPDATE: w_upd_go   = !r_o_valid || o_out.ready;
            default:   w_in_ready = 1'b0;
        endcase
    end

    // choose the frame for the update state
    always_comb begin
        if (r_found) begin
            w_ch_idx = r_sel_idx;
            w_ch_cnt = r_sel_cnt;
        end else if (r_have_empty) begin
            w_ch_idx = r_emp_idx;
            w_ch_cnt = r_emp_cnt;
        end else begin
            w_ch_idx = r_min_idx;
            w_ch_cnt = r_min_cnt;
        end
        w_new_cnt = sat_inc(w_ch_cnt);
        w_wr.we   = w_upd_go;
        w_wr.idx  = w_ch_idx;
        w_wr.page = r_page;
        w_wr.cnt  = w_new_cnt;
    end

    // datapath next values
    always_comb begin
        n_j          = r_j;
        n_page       = r_page;
        n_found      = r_found;
        n_have_empty = r_have_empty;
        n_sel_idx    = r_sel_idx;
        n_sel_cnt    = r_sel_cnt;
        n_emp_idx    = r_emp_idx;
        n_emp_cnt    = r_emp_cnt;
        n_min_idx    = r_min_idx;
        n_min_cnt    = r_min_cnt;
        n_min_page   = r_min_page;
        n_o_valid    = r_o_valid && !o_out.ready;
        n_o_hit      = r_o_hit;
        n_o_idx      = r_o_idx;
        n_o_action   = r_o_action;
        n_o_evict    = r_o_evict;
        n_o_count    = r_o_count;

        if (w_in_ready && i_in.valid) begin
            n_page       = PAGE_BITS'(i_in.page);
            n_j          = '0;
            n_found      = 1'b0;
            n_have_empty = 1'b0;
        end

        if (w_scan_en) begin
            n_j = r_j + t_idx'(1);
            if (w_cmp.match) begin
                n_found   = 1'b1;
                n_sel_idx = r_j;
                n_sel_cnt = w_rd_cnt;
            end else if (w_cmp.empty && !r_have_empty) begin
                n_have_empty = 1'b1;
                n_emp_idx    = r_j;
                n_emp_cnt    = w_rd_cnt;
            end
            if (w_cmp.less) begin
                n_min_idx  = r_j;
                n_min_cnt  = w_rd_cnt;
                n_min_page = w_rd_page;
            end
        end

        if (w_upd_go) begin
            n_o_valid = 1'b1;
            n_o_hit   = r_found;
            n_o_idx   = INDEX_W'(w_ch_idx);
            n_o_count = USE_W'(w_new_cnt);
            if (r_found) begin
                n_o_action = ACT_HIT;
                n_o_evict  = '0;
            end else if (r_have_empty) begin
                n_o_action = ACT_FILL;
                n_o_evict  = '0;
            end else begin
                n_o_action = ACT_REPLACE;
                n_o_evict  = EVICT_W'(r_min_page);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_frames     <= CFG_RESET;
            r_o_valid    <= 1'b0;
            r_found      <= 1'b0;
            r_have_empty <= 1'b0;
            r_j          <= '0;
        end else begin
            r_state      <= n_state;
            r_o_valid    <= n_o_valid;
            r_found      <= n_found;
            r_have_empty <= n_have_empty;
            r_j          <= n_j;
            if (i_cfg_we) r_frames <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_sel_idx  <= n_sel_idx;
        r_sel_cnt  <= n_sel_cnt;
        r_emp_idx  <= n_emp_idx;
        r_emp_cnt  <= n_emp_cnt;
        r_min_idx  <= n_min_idx;
        r_min_cnt  <= n_min_cnt;
        r_min_page <= n_min_page;
        r_o_hit    <= n_o_hit;
        r_o_idx    <= n_o_idx;
        r_o_action <= n_o_action;
        r_o_evict  <= n_o_evict;
        r_o_count  <= n_o_count;
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_o_valid;
    assign o_out.hit          = r_o_hit;
    assign o_out.frame_index  = r_o_idx;
    assign o_out.action       = r_o_action;
    assign o_out.evicted_page = r_o_evict;
    assign o_out.use_count    = r_o_count;

endmodule

// ===== src/ucpr_checker.sv =====
// ----------------------------------------------------------------------------
// ucpr_checker
// Port-level checks for the use-count page replacement core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_hit,
    input logic [ucpr_pkg::INDEX_W-1:0]  i_frame_index,
    input ucpr_pkg::t_action             i_action,
    input logic [ucpr_pkg::EVICT_W-1:0]  i_evicted_page,
    input logic [ucpr_pkg::USE_W-1:0]    i_use_count
);
    import ucpr_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_frame_index) && $stable(i_use_count),
        "stalled result changed")
    `ASSERT_NEXT(a_busy_after_req, i_in_valid && i_in_ready, !i_in_ready,
        "request taken while a search is running")
    `ASSERT_NOW(a_hit_action, i_out_valid, i_hit == (i_action == ACT_HIT),
        "hit flag disagrees with action")
    `ASSERT_NOW(a_evict_only_replace, i_out_valid && (i_action != ACT_REPLACE),
        i_evicted_page == '0, "evicted page without replacement")
    `ASSERT_NOW(a_count_nonzero, i_out_valid, i_use_count != '0,
        "use count zero after increment")

endmodule

bind use_count_page_replacement_core ucpr_checker u_ucpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_hit          (o_out.hit),
    .i_frame_index  (o_out.frame_index),
    .i_action       (o_out.action),
    .i_evicted_page (o_out.evicted_page),
    .i_use_count    (o_out.use_count)
);
